### rtl/ip4_pkg.sv
// shared types, codes and pixel source table for the intra 4x4 luma predictor
package ip4_pkg;

  localparam logic [3:0] MODE_VERT       = 4'd0;
  localparam logic [3:0] MODE_HOR        = 4'd1;
  localparam logic [3:0] MODE_DC         = 4'd2;
  localparam logic [3:0] MODE_DIAG_DL    = 4'd3;
  localparam logic [3:0] MODE_DIAG_DR    = 4'd4;
  localparam logic [3:0] MODE_VERT_RIGHT = 4'd5;
  localparam logic [3:0] MODE_HOR_DOWN   = 4'd6;
  localparam logic [3:0] MODE_VERT_LEFT  = 4'd7;
  localparam logic [3:0] MODE_HOR_UP     = 4'd8;

  localparam int unsigned NUM_MODES = 9;
  localparam int unsigned NUM_EDGE  = 13;
  localparam logic [7:0]  PIX_MID   = 8'd128;

  typedef struct packed {
    logic [3:0]  pred_mode;
    logic [31:0] left_pixels;
    logic [7:0]  corner_pixel;
    logic [31:0] top_pixels;
    logic [31:0] top_right_pixels;
    logic        left_valid;
    logic        top_valid;
    logic        corner_valid;
    logic        top_right_valid;
  } in_t;

  typedef struct packed {
    logic [31:0] pred_row0;
    logic [31:0] pred_row1;
    logic [31:0] pred_row2;
    logic [31:0] pred_row3;
  } out_t;

  // where a predicted pixel comes from
  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_EDGE,
    SRC_AVG,
    SRC_FLT,
    SRC_DC
  } src_e;

  typedef struct packed {
    src_e       kind;
    logic [3:0] idx;
  } sel_t;

  // edge line: 0..3 left rows 3..0, 4 corner, 5..12 top columns 0..7
  // SRC_AVG idx i: average of edge i and i+1
  // SRC_FLT idx i: 1-2-1 filter centred on edge i, ends clamped
  function automatic sel_t pix_sel(logic [3:0] mode, int x, int y);
    sel_t s;
    int   z;
    int   c;
    s.kind = SRC_ZERO;
    s.idx  = '0;
    c      = 0;
    case (mode)
      MODE_VERT: begin
        s.kind = SRC_EDGE;
        c      = 5 + x;
      end
      MODE_HOR: begin
        s.kind = SRC_EDGE;
        c      = 3 - y;
      end
      MODE_DC: begin
        s.kind = SRC_DC;
      end
      MODE_DIAG_DL: begin
        s.kind = SRC_FLT;
        if (x == 3 && y == 3) c = 12;
        else                  c = 6 + x + y;
      end
      MODE_DIAG_DR: begin
        s.kind = SRC_FLT;
        c      = 4 + x - y;
      end
      MODE_VERT_RIGHT: begin
        z = 2 * x - y;
        if (z >= 0 && (z & 1) == 0) begin
          s.kind = SRC_AVG;
          c      = 4 + x - (y >> 1);
        end else if (z > 0) begin
          s.kind = SRC_FLT;
          c      = 4 + x - (y >> 1);
        end else if (z == -1) begin
          s.kind = SRC_FLT;
          c      = 4;
        end else begin
          s.kind = SRC_FLT;
          c      = 5 - y;
        end
      end
      MODE_HOR_DOWN: begin
        z = 2 * y - x;
        if (z >= 0 && (z & 1) == 0) begin
          s.kind = SRC_AVG;
          c      = 3 - y + (x >> 1);
        end else if (z > 0) begin
          s.kind = SRC_FLT;
          c      = 4 - y + (x >> 1);
        end else if (z == -1) begin
          s.kind = SRC_FLT;
          c      = 4;
        end else begin
          s.kind = SRC_FLT;
          c      = 3 + x;
        end
      end
      MODE_VERT_LEFT: begin
        if ((y & 1) == 0) begin
          s.kind = SRC_AVG;
          c      = 5 + x + (y >> 1);
        end else begin
          s.kind = SRC_FLT;
          c      = 6 + x + (y >> 1);
        end
      end
      MODE_HOR_UP: begin
        z = x + 2 * y;
        if (z == 0 || z == 2 || z == 4) begin
          s.kind = SRC_AVG;
          c      = 2 - y - (x >> 1);
        end else if (z == 1 || z == 3) begin
          s.kind = SRC_FLT;
          c      = 2 - y - (x >> 1);
        end else if (z == 5) begin
          s.kind = SRC_FLT;
          c      = 0;
        end else begin
          s.kind = SRC_EDGE;
          c      = 0;
        end
      end
      default: begin
        s.kind = SRC_ZERO;
      end
    endcase
    s.idx = 4'(c);
    return s;
  endfunction

endpackage

### rtl/ip4_in_if.sv
// request channel carrying one block's neighbour pixels and mode
interface ip4_in_if;
  logic         valid;
  logic         ready;
  ip4_pkg::in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/ip4_out_if.sv
// result channel carrying the four predicted rows of one block
interface ip4_out_if;
  logic          valid;
  logic          ready;
  ip4_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/ip4_datapath.sv
// combinational neighbour substitution, edge filters and per-pixel select
module ip4_datapath (
  input  ip4_pkg::in_t  blk_i,
  output ip4_pkg::out_t pred_o
);

  logic [7:0]  edge_px [ip4_pkg::NUM_EDGE];
  logic [7:0]  avg_px  [ip4_pkg::NUM_EDGE-1];
  logic [7:0]  flt_px  [ip4_pkg::NUM_EDGE];
  logic [9:0]  sum_left;
  logic [9:0]  sum_top;
  logic [10:0] sum_both;
  logic [9:0]  dc_left;
  logic [9:0]  dc_top;
  logic [7:0]  dc_px;
  logic [7:0]  pix [16];

  // substituted edge line
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      edge_px[3-k] = blk_i.left_valid ? blk_i.left_pixels[8*k +: 8] : ip4_pkg::PIX_MID;
      edge_px[5+k] = blk_i.top_valid  ? blk_i.top_pixels[8*k +: 8]  : ip4_pkg::PIX_MID;
    end
    edge_px[4] = blk_i.corner_valid ? blk_i.corner_pixel : ip4_pkg::PIX_MID;
    for (int k = 0; k < 4; k++) begin
      edge_px[9+k] = blk_i.top_right_valid ? blk_i.top_right_pixels[8*k +: 8] : edge_px[8];
    end
  end

  // two-tap averages and three-tap filters along the edge
  logic [8:0] avg_sum [ip4_pkg::NUM_EDGE-1];
  logic [9:0] flt_sum [ip4_pkg::NUM_EDGE];

  for (genvar i = 0; i < ip4_pkg::NUM_EDGE - 1; i++) begin : g_avg
    assign avg_sum[i] = {1'b0, edge_px[i]} + {1'b0, edge_px[i+1]} + 9'd1;
    assign avg_px[i]  = avg_sum[i][8:1];
  end

  for (genvar i = 0; i < ip4_pkg::NUM_EDGE; i++) begin : g_flt
    localparam int Lo = (i == 0) ? 0 : i - 1;
    localparam int Hi = (i == ip4_pkg::NUM_EDGE - 1) ? i : i + 1;
    assign flt_sum[i] = {2'b00, edge_px[Lo]} + {1'b0, edge_px[i], 1'b0}
                      + {2'b00, edge_px[Hi]} + 10'd2;
    assign flt_px[i]  = flt_sum[i][9:2];
  end

  // dc from whichever of left and top are available
  always_comb begin
    sum_left = {2'b00, edge_px[0]} + {2'b00, edge_px[1]}
             + {2'b00, edge_px[2]} + {2'b00, edge_px[3]};
    sum_top  = {2'b00, edge_px[5]} + {2'b00, edge_px[6]}
             + {2'b00, edge_px[7]} + {2'b00, edge_px[8]};
    sum_both = {1'b0, sum_left} + {1'b0, sum_top} + 11'd4;
    dc_left  = sum_left + 10'd2;
    dc_top   = sum_top + 10'd2;
    if (blk_i.left_valid && blk_i.top_valid) begin
      dc_px = sum_both[10:3];
    end else if (blk_i.left_valid) begin
      dc_px = dc_left[9:2];
    end else if (blk_i.top_valid) begin
      dc_px = dc_top[9:2];
    end else begin
      dc_px = ip4_pkg::PIX_MID;
    end
  end

  // per pixel: one candidate per mode, picked by the mode code
  for (genvar p = 0; p < 16; p++) begin : g_pix
    logic [7:0] cand [ip4_pkg::NUM_MODES];

    for (genvar m = 0; m < ip4_pkg::NUM_MODES; m++) begin : g_mode
      localparam ip4_pkg::sel_t Sel = ip4_pkg::pix_sel(4'(m), p % 4, p / 4);
      if (Sel.kind == ip4_pkg::SRC_EDGE) begin : g_edge
        assign cand[m] = edge_px[Sel.idx];
      end else if (Sel.kind == ip4_pkg::SRC_AVG) begin : g_a
        assign cand[m] = avg_px[Sel.idx];
      end else if (Sel.kind == ip4_pkg::SRC_FLT) begin : g_f
        assign cand[m] = flt_px[Sel.idx];
      end else if (Sel.kind == ip4_pkg::SRC_DC) begin : g_dc
        assign cand[m] = dc_px;
      end else begin : g_zero
        assign cand[m] = 8'd0;
      end
    end

    always_comb begin
      if (blk_i.pred_mode <= ip4_pkg::MODE_HOR_UP) begin
        pix[p] = cand[blk_i.pred_mode];
      end else begin
        pix[p] = 8'd0;
      end
    end
  end

  assign pred_o.pred_row0 = {pix[3],  pix[2],  pix[1],  pix[0]};
  assign pred_o.pred_row1 = {pix[7],  pix[6],  pix[5],  pix[4]};
  assign pred_o.pred_row2 = {pix[11], pix[10], pix[9],  pix[8]};
  assign pred_o.pred_row3 = {pix[15], pix[14], pix[13], pix[12]};

endmodule

### rtl/intra4x4_luma_predictor.sv
// top level of the intra 4x4 luma predictor: input register, datapath, result register
//
// Forms the sixteen predicted pixels of one 4x4 luma block from its thirteen
// neighbours for any of the nine standard intra 4x4 modes. Unavailable left,
// top and corner pixels are taken as 128, missing top-right pixels repeat the
// last top pixel, and DC averages whichever of left and top are present (128
// when neither is). Mode codes 9 to 15 give an all-zero block. One block is
// accepted every clock cycle unless the result side stalls with both
// registers full. The block goes from the input register through a single
// combinational pass of edge filters and per-pixel selection into the result
// register, from which its rows are offered on the result side.
// A stall on the result side holds both registers and lowers ready on the
// request side only once both are full. There is no configuration and no
// state carried from one block to the next.
module intra4x4_luma_predictor (
  input  logic       clk_i,
  input  logic       rst_ni,
  ip4_in_if.sink     pix_i,
  ip4_out_if.source  pred_o
);

  // stage one: captured request
  logic          s1_v_q;
  ip4_pkg::in_t  s1_data_q;
  // stage two: result waiting to be taken
  logic          out_v_q;
  ip4_pkg::out_t out_data_q;

  ip4_pkg::out_t pred_d;
  logic          out_load;
  logic          s1_load;

  // result register frees up when empty or being taken this cycle
  assign out_load    = !out_v_q || pred_o.ready;
  // stage one may take a new request when empty or moving on
  assign s1_load     = !s1_v_q || out_load;
  assign pix_i.ready = s1_load;

  ip4_datapath u_datapath (
    .blk_i  (s1_data_q),
    .pred_o (pred_d)
  );

  // control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_v_q <= pix_i.valid;
      end
      if (out_load) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  // payload flops, no reset needed
  always_ff @(posedge clk_i) begin
    if (s1_load && pix_i.valid) begin
      s1_data_q <= pix_i.data;
    end
    if (out_load && s1_v_q) begin
      out_data_q <= pred_d;
    end
  end

  assign pred_o.valid = out_v_q;
  assign pred_o.data  = out_data_q;

  // ready only drops while stage one holds a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> s1_v_q)
    else $error("request side stalled with stage one empty");

  // an accepted request always lands in stage one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready) |=> s1_v_q)
    else $error("accepted request lost before stage one");

  // a request in stage one moves into the result register when it is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && out_load) |=> out_v_q)
    else $error("stage one request not passed to result register");

  // a stalled result keeps its rows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !pred_o.ready) |=> (out_v_q && $stable(out_data_q)))
    else $error("stalled result changed or dropped");

endmodule
